// File: src/ils_pkg.sv
`default_nettype none

package ils_pkg;

  // Request codes carried on req_type_i.
  typedef enum logic [1:0] {
    REQ_FRONT  = 2'd0,
    REQ_BACK   = 2'd1,
    REQ_REMOVE = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  // Status codes reported with every result of a readout.
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Controller states, one-hot.
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SHIFT = 5'b00010,
    S_DRAIN = 5'b00100,
    S_HEAD  = 5'b01000,
    S_READ  = 5'b10000
  } state_e;

  localparam int unsigned ELEM_W = 32;

endpackage

`default_nettype wire

// File: src/ils_mem.sv
`default_nettype none

module ils_mem
  import ils_pkg::*;
#(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  wire logic              clk_i,
  input  wire logic              wr_en_i,
  input  wire logic [AW-1:0]     wr_addr_i,
  input  wire logic [ELEM_W-1:0] wr_data_i,
  input  wire logic              rd_en_i,
  input  wire logic [AW-1:0]     rd_addr_i,
  output logic      [ELEM_W-1:0] rd_data_o
);

  logic [ELEM_W-1:0] mem_q [DEPTH];

  // Single write port, single registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// File: src/ils_ctrl.sv
`default_nettype none

module ils_ctrl
  import ils_pkg::*;
#(
  parameter int unsigned CAPACITY = 32,
  parameter int unsigned AW       = 5,
  parameter int unsigned CW       = 6
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        req_type_i,
  input  wire logic [ELEM_W-1:0] item_value_i,
  input  wire logic [31:0]       position_i,
  output logic                   mem_wr_en_o,
  output logic [AW-1:0]          mem_wr_addr_o,
  output logic [ELEM_W-1:0]      mem_wr_data_o,
  output logic                   mem_rd_en_o,
  output logic [AW-1:0]          mem_rd_addr_o,
  input  wire logic [ELEM_W-1:0] mem_rd_data_i,
  output logic                   result_valid_o,
  output logic [ELEM_W-1:0]      elem_value_o,
  output logic                   last_elem_o,
  output logic                   list_empty_o,
  output logic [1:0]             req_status_o
);

  state_e            state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic [AW-1:0]     end_q, end_d;
  logic              dir_up_q, dir_up_d;
  logic [ELEM_W-1:0] val_q, val_d;
  logic              wpend_q, wpend_d;
  logic [AW-1:0]     wdst_q, wdst_d;
  logic              out_valid_q, out_valid_d;
  logic              last_q, last_d;
  logic              empty_q, empty_d;
  status_e           status_q, status_d;
  logic              accept;
  logic              full;
  logic              pos_bad;
  logic              pos_is_tail;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign full   = (count_q == CW'(CAPACITY));

  // A remove position is bad when negative or not below the element count.
  assign pos_bad     = position_i[31] || ({1'b0, position_i[30:0]} >= 32'(count_q));
  assign pos_is_tail = (position_i[30:0] == (31'(count_q) - 31'd1));

  // Sequencer: decode the request, shift entries through the memory, then read out.
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    ptr_d         = ptr_q;
    end_d         = end_q;
    dir_up_d      = dir_up_q;
    val_d         = val_q;
    wpend_d       = 1'b0;
    wdst_d        = wdst_q;
    out_valid_d   = 1'b0;
    last_d        = last_q;
    empty_d       = empty_q;
    status_d      = status_q;
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = ptr_q;
    // A shifted entry is written back in the cycle after its read.
    mem_wr_en_o   = wpend_q;
    mem_wr_addr_o = wdst_q;
    mem_wr_data_o = mem_rd_data_i;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          status_d = ST_DONE;
          ptr_d    = '0;
          state_d  = S_READ;
          case (req_type_i)
            REQ_FRONT: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                count_d = count_q + CW'(1);
                if (count_q == '0) begin
                  mem_wr_en_o   = 1'b1;
                  mem_wr_addr_o = '0;
                  mem_wr_data_o = item_value_i;
                end else begin
                  ptr_d    = AW'(count_q - CW'(1));
                  end_d    = '0;
                  dir_up_d = 1'b0;
                  val_d    = item_value_i;
                  state_d  = S_SHIFT;
                end
              end
            end
            REQ_BACK: begin
              if (full) begin
                status_d = ST_FULL;
              end else begin
                count_d       = count_q + CW'(1);
                mem_wr_en_o   = 1'b1;
                mem_wr_addr_o = AW'(count_q);
                mem_wr_data_o = item_value_i;
              end
            end
            REQ_REMOVE: begin
              if (pos_bad) begin
                status_d = ST_RANGE;
              end else begin
                count_d = count_q - CW'(1);
                if (!pos_is_tail) begin
                  ptr_d    = AW'(position_i[30:0]) + AW'(1);
                  end_d    = AW'(count_q - CW'(1));
                  dir_up_d = 1'b1;
                  state_d  = S_SHIFT;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SHIFT: begin
        mem_rd_en_o = 1'b1;
        wpend_d     = 1'b1;
        wdst_d      = dir_up_q ? (ptr_q - AW'(1)) : (ptr_q + AW'(1));
        if (ptr_q == end_q) begin
          state_d = S_DRAIN;
        end else begin
          ptr_d = dir_up_q ? (ptr_q + AW'(1)) : (ptr_q - AW'(1));
        end
      end

      S_DRAIN: begin
        ptr_d   = '0;
        state_d = dir_up_q ? S_READ : S_HEAD;
      end

      S_HEAD: begin
        mem_wr_en_o   = 1'b1;
        mem_wr_addr_o = '0;
        mem_wr_data_o = val_q;
        ptr_d         = '0;
        state_d       = S_READ;
      end

      S_READ: begin
        out_valid_d = 1'b1;
        if (count_q == '0) begin
          empty_d = 1'b1;
          last_d  = 1'b1;
          state_d = S_IDLE;
        end else begin
          mem_rd_en_o = 1'b1;
          empty_d     = 1'b0;
          last_d      = (CW'(ptr_q) == (count_q - CW'(1)));
          if (CW'(ptr_q) == (count_q - CW'(1))) begin
            state_d = S_IDLE;
          end else begin
            ptr_d = ptr_q + AW'(1);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      wpend_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      wpend_q     <= wpend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    end_q    <= end_d;
    dir_up_q <= dir_up_d;
    val_q    <= val_d;
    wdst_q   <= wdst_d;
    last_q   <= last_d;
    empty_q  <= empty_d;
    status_q <= status_d;
  end

  assign result_valid_o = out_valid_q;
  assign elem_value_o   = empty_q ? '0 : mem_rd_data_i;
  assign last_elem_o    = last_q;
  assign list_empty_o   = empty_q;
  assign req_status_o   = status_q;

  // The element count never passes the store size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("element count above capacity");

  // A shifted entry is only ever written back right after a shift read.
  a_wpend_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wpend_q |-> $past(state_q == S_SHIFT))
    else $error("write-back without a preceding shift read");

  // An empty readout is a single, final transfer.
  a_empty_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && empty_q) |-> (last_q && count_q == '0))
    else $error("empty result not marked last");

  // The readout pointer stays inside the list.
  a_read_ptr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ && count_q != '0) |-> (CW'(ptr_q) < count_q))
    else $error("readout pointer past the list end");

endmodule

`default_nettype wire

// File: src/indexed_list_store.sv
// Ordered list of signed 32-bit values kept packed in an on-chip memory.
// Requests: start, req_type_i, item_value_i, position_i; a request transfers
// at a rising edge where start is high and busy is low. Results: after each
// request the list is read out front to back, one transfer per element, each
// shown for one cycle while result_valid_o is high; last_elem_o marks the
// final one, an empty list gives one transfer with list_empty_o set and
// elem_value_o zero, and all transfers carry the same req_status_o. The
// receiver cannot stall, so results are never held.
//
// The controller goes straight from idle to the readout for
// append, no change, a rejected request, a remove of the tail or an insert
// into an empty list. A remove first moves the following entries down at
// one per cycle, then passes a drain state; a front insert moves all older
// entries up at one per cycle, then passes a drain state and writes the new
// head. The readout is limited by the single memory read port. busy drops
// as the last result appears, so the next request may transfer at the edge
// ending it. The slowest request is a front insert into CAPACITY-1 elements.
// Reset empties the list at once; memory contents need no clearing.

`default_nettype none

module indexed_list_store
  import ils_pkg::*;
#(
  parameter int unsigned CAPACITY = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        req_type_i,
  input  wire logic [ELEM_W-1:0] item_value_i,
  input  wire logic [31:0]       position_i,
  output logic                   result_valid_o,
  output logic [ELEM_W-1:0]      elem_value_o,
  output logic                   last_elem_o,
  output logic                   list_empty_o,
  output logic [1:0]             req_status_o
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  logic              mem_wr_en;
  logic [AW-1:0]     mem_wr_addr;
  logic [ELEM_W-1:0] mem_wr_data;
  logic              mem_rd_en;
  logic [AW-1:0]     mem_rd_addr;
  logic [ELEM_W-1:0] mem_rd_data;

  // Sequencer for request decode, entry shifting and readout.
  ils_ctrl #(
    .CAPACITY (CAPACITY),
    .AW       (AW),
    .CW       (CW)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .item_value_i   (item_value_i),
    .position_i     (position_i),
    .mem_wr_en_o    (mem_wr_en),
    .mem_wr_addr_o  (mem_wr_addr),
    .mem_wr_data_o  (mem_wr_data),
    .mem_rd_en_o    (mem_rd_en),
    .mem_rd_addr_o  (mem_rd_addr),
    .mem_rd_data_i  (mem_rd_data),
    .result_valid_o (result_valid_o),
    .elem_value_o   (elem_value_o),
    .last_elem_o    (last_elem_o),
    .list_empty_o   (list_empty_o),
    .req_status_o   (req_status_o)
  );

  // Element storage.
  ils_mem #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_mem (
    .clk_i     (clk_i),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rd_data_o (mem_rd_data)
  );

endmodule

`default_nettype wire

// File: tb/tb_indexed_list_store.sv
`timescale 1ns / 1ps

module tb_indexed_list_store;
  import ils_pkg::*;

  localparam int unsigned CAPACITY = 32;
  localparam int unsigned RANDOM_ITEMS = 190;
  localparam int unsigned DRAIN_CYCLES = 80;

  // One request waiting to be driven.
  typedef struct {
    req_e        kind;
    logic [31:0] value;
    logic [31:0] pos;
  } list_req_t;

  // One element of a readout as the block should show it.
  typedef struct {
    logic [31:0] elem_value;
    logic        last_elem;
    logic        list_empty;
    status_e     req_status;
  } readout_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type_i = REQ_NONE;
  logic [31:0] item_value_i = '0;
  logic [31:0] position_i = '0;
  logic        result_valid_o;
  logic [31:0] elem_value_o;
  logic        last_elem_o;
  logic        list_empty_o;
  logic [1:0]  req_status_o;

  list_req_t   pending_reqs[$];
  readout_t    expected_readout[$];
  logic [31:0] list_model[$];
  int          gen_count = 0;
  int          gap_left = 0;
  int          quiet_left = 0;
  int          mismatch_count = 0;
  list_req_t   next_req;
  readout_t    seen_exp;

  indexed_list_store #(
    .CAPACITY(CAPACITY)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .req_type_i    (req_type_i),
    .item_value_i  (item_value_i),
    .position_i    (position_i),
    .result_valid_o(result_valid_o),
    .elem_value_o  (elem_value_o),
    .last_elem_o   (last_elem_o),
    .list_empty_o  (list_empty_o),
    .req_status_o  (req_status_o)
  );

  // Free-running clock, 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Applies one request to the list copy and queues the readout it produces.
  function automatic void apply_list_request(req_e kind, logic [31:0] value,
                                             logic [31:0] pos);
    status_e  status;
    readout_t entry;
    status = ST_DONE;
    case (kind)
      REQ_FRONT, REQ_BACK: begin
        if (list_model.size() >= CAPACITY) begin
          status = ST_FULL;
        end else if (kind == REQ_FRONT) begin
          list_model.push_front(value);
        end else begin
          list_model.push_back(value);
        end
      end
      REQ_REMOVE: begin
        // A set sign bit means a negative position.
        if (pos[31] || pos >= list_model.size()) begin
          status = ST_RANGE;
        end else begin
          list_model.delete(int'(pos));
        end
      end
      default: begin
      end
    endcase
    if (list_model.size() == 0) begin
      entry = '{elem_value: '0, last_elem: 1'b1, list_empty: 1'b1, req_status: status};
      expected_readout.push_back(entry);
    end else begin
      for (int i = 0; i < list_model.size(); i++) begin
        entry = '{elem_value: list_model[i], last_elem: (i == list_model.size() - 1),
                  list_empty: 1'b0, req_status: status};
        expected_readout.push_back(entry);
      end
    end
  endfunction

  // Idle time after a transfer: mostly none, sometimes short, rarely long,
  // with occasional stretches of back-to-back requests.
  function automatic int pick_gap();
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      quiet_left = $urandom_range(8, 20);
      return 0;
    end else if (r < 55) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 4);
    end
    return $urandom_range(5, 45);
  endfunction

  // Queues a request and tracks the element count it will leave behind.
  task automatic add_request(req_e kind, logic [31:0] value, logic [31:0] pos);
    pending_reqs.push_back('{kind: kind, value: value, pos: pos});
    case (kind)
      REQ_FRONT, REQ_BACK: if (gen_count < CAPACITY) gen_count++;
      REQ_REMOVE: if (!pos[31] && pos < gen_count) gen_count--;
      default: begin
      end
    endcase
  endtask

  // Picks a remove position: mostly in range, otherwise past the end,
  // negative or fully random.
  function automatic logic [31:0] pick_position();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7 && gen_count > 0) begin
      return $urandom_range(0, gen_count - 1);
    end else if (r < 8) begin
      return gen_count;
    end else if (r < 9) begin
      return $urandom() | 32'h8000_0000;
    end
    return $urandom();
  endfunction

  // Request driver: one transfer per accepted start, then a random gap.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_list_request(req_e'(req_type_i), item_value_i, position_i);
        gap_left = pick_gap();
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          start <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          next_req = pending_reqs.pop_front();
          req_type_i <= next_req.kind;
          item_value_i <= next_req.value;
          position_i <= next_req.pos;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor: every transfer is matched against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (expected_readout.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected result: value %h last %b empty %b status %0d",
                   elem_value_o, last_elem_o, list_empty_o, req_status_o);
        end
      end else begin
        seen_exp = expected_readout.pop_front();
        if (elem_value_o !== seen_exp.elem_value || last_elem_o !== seen_exp.last_elem ||
            list_empty_o !== seen_exp.list_empty || req_status_o !== seen_exp.req_status) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("mismatch: expected value %h last %b empty %b status %0d",
                     seen_exp.elem_value, seen_exp.last_elem, seen_exp.list_empty,
                     seen_exp.req_status);
            $display("          got      value %h last %b empty %b status %0d",
                     elem_value_o, last_elem_o, list_empty_o, req_status_o);
          end
        end
      end
    end
  end

  // Stimulus and end of run.
  initial begin
    int     mode;
    int     burst;
    int     r;
    int     random_done;
    req_e   kind;

    // Directed part: empty list, value extremes, every request type and
    // every out-of-range form of a remove.
    add_request(REQ_NONE, 32'h1234_5678, 32'h0000_0003);
    add_request(REQ_REMOVE, 32'h0, 32'h0);
    add_request(REQ_REMOVE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_request(REQ_BACK, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    add_request(REQ_FRONT, 32'h8000_0000, 32'h8000_0000);
    add_request(REQ_BACK, 32'h0000_0000, 32'h7FFF_FFFF);
    add_request(REQ_FRONT, 32'hFFFF_FFFF, 32'h0);
    add_request(REQ_NONE, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    add_request(REQ_REMOVE, 32'h0, 32'h8000_0000);
    add_request(REQ_REMOVE, 32'h0, 32'h7FFF_FFFF);
    add_request(REQ_REMOVE, 32'h0, 32'd4);
    add_request(REQ_REMOVE, 32'h0, 32'd3);
    add_request(REQ_REMOVE, 32'h0, 32'd1);
    add_request(REQ_REMOVE, 32'h0, 32'd0);
    add_request(REQ_REMOVE, 32'h0, 32'd0);
    add_request(REQ_BACK, 32'h5555_5555, 32'h0);
    add_request(REQ_FRONT, 32'hAAAA_AAAA, 32'h0);
    add_request(REQ_REMOVE, 32'hFFFF_FFFF, 32'd1);
    add_request(REQ_REMOVE, 32'hFFFF_FFFF, 32'd0);

    // Fill the list past capacity so that inserts get dropped.
    random_done = 0;
    repeat (CAPACITY + 4) begin
      kind = ($urandom_range(0, 1) == 0) ? REQ_FRONT : REQ_BACK;
      add_request(kind, $urandom(), $urandom());
      random_done++;
    end

    // Random bursts that grow, shrink or churn the list.
    while (random_done < RANDOM_ITEMS) begin
      mode = $urandom_range(0, 2);
      burst = $urandom_range(10, 30);
      repeat (burst) begin
        r = $urandom_range(0, 99);
        if ((mode == 0 && r < 85) || (mode == 2 && r < 10) || (mode == 1 && r < 40)) begin
          kind = ($urandom_range(0, 1) == 0) ? REQ_FRONT : REQ_BACK;
        end else if ((mode == 0 && r < 95) || (mode == 2 && r < 90) ||
                     (mode == 1 && r < 85)) begin
          kind = REQ_REMOVE;
        end else begin
          kind = REQ_NONE;
        end
        if (kind == REQ_REMOVE) begin
          add_request(kind, $urandom(), pick_position());
        end else begin
          add_request(kind, $urandom(), $urandom());
        end
        random_done++;
      end
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_reqs.size() == 0 && rst_ni && !start);
    wait (expected_readout.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && expected_readout.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #1_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
